// File: rtl/core/hcic_pkg.sv
// Shared constants and types of the Hilbert curve index converter.
`default_nettype none
package hcic_pkg;

	localparam int DIMS_DEF = 2;
	localparam int BITS_DEF = 32;
	localparam int OP_W     = 64;
	localparam int OP_IW    = $clog2(OP_W);

	typedef enum logic {
		CMD_TO_COORD = 1'b0,
		CMD_TO_INDEX = 1'b1
	} hcic_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/hcic_in_if.sv
// Request channel of the converter: command and operand.
`default_nettype none
interface hcic_in_if;
	logic                         valid;
	logic                         ready;
	hcic_pkg::hcic_cmd_t          cmd;
	logic [hcic_pkg::OP_W-1:0]    operand_in;

	modport source(output valid, cmd, operand_in, input ready);
	modport sink(input valid, cmd, operand_in, output ready);
endinterface
`default_nettype wire

// File: rtl/core/hcic_out_if.sv
// Response channel of the converter: converted operand.
`default_nettype none
interface hcic_out_if;
	logic                         valid;
	logic                         ready;
	logic [hcic_pkg::OP_W-1:0]    operand_out;

	modport source(output valid, operand_out, input ready);
	modport sink(input valid, operand_out, output ready);
endinterface
`default_nettype wire

// File: rtl/core/hcic_level.sv
// One curve level: chunk conversion, child corner update and its stage register.
`default_nettype none
module hcic_level #(
	parameter int DIMS  = hcic_pkg::DIMS_DEF,
	parameter int BITS  = hcic_pkg::BITS_DEF,
	parameter int LEVEL = 0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output      logic                       in_ready,
	input  wire hcic_pkg::hcic_cmd_t        in_cmd,
	input  wire logic [hcic_pkg::OP_W-1:0]  in_operand,
	input  wire logic [hcic_pkg::OP_W-1:0]  in_res,
	input  wire logic [DIMS-1:0]            in_start,
	input  wire logic [DIMS-1:0]            in_end,
	output      logic                       out_valid,
	input  wire logic                       out_ready,
	output      hcic_pkg::hcic_cmd_t        out_cmd,
	output      logic [hcic_pkg::OP_W-1:0]  out_operand,
	output      logic [hcic_pkg::OP_W-1:0]  out_res,
	output      logic [DIMS-1:0]            out_start,
	output      logic [DIMS-1:0]            out_end
);
	import hcic_pkg::*;

	localparam int C  = BITS - 1 - LEVEL;
	localparam int TW = $clog2(DIMS);

	function automatic logic [DIMS-1:0] rot_l(input logic [DIMS-1:0] x,
		input logic [TW-1:0] r);
		logic [2*DIMS-1:0] d;
		d = {x, x} << r;
		return d[2*DIMS-1:DIMS];
	endfunction

	function automatic logic [DIMS-1:0] rot_r(input logic [DIMS-1:0] x,
		input logic [TW-1:0] r);
		logic [2*DIMS-1:0] d;
		d = {x, x} >> r;
		return d[DIMS-1:0];
	endfunction

	function automatic logic [DIMS-1:0] gray(input logic [DIMS-1:0] x);
		return x ^ (x >> 1);
	endfunction

	function automatic logic [DIMS-1:0] gray_inv(input logic [DIMS-1:0] g);
		logic [DIMS-1:0] b;
		b[DIMS-1] = g[DIMS-1];
		for (int k = DIMS - 2; k >= 0; k--) begin
			b[k] = b[k+1] ^ g[k];
		end
		return b;
	endfunction

	// Lowest set bit of the travel word; zero when none.
	function automatic logic [TW-1:0] travel_pos(input logic [DIMS-1:0] d);
		logic [TW-1:0] p;
		p = '0;
		for (int k = DIMS - 1; k >= 0; k--) begin
			if (d[k]) begin
				p = TW'(k);
			end
		end
		return p;
	endfunction

	logic [DIMS-1:0]  idx_chunk, crd_chunk, cc, sub_i, si, ei;
	logic [DIMS:0]    ei_wide;
	logic [TW-1:0]    t, ra;
	logic [OP_W-1:0]  res_next;
	logic [DIMS-1:0]  start_next, end_next;

	logic             valid_s1;
	hcic_cmd_t        cmd_s1;
	logic [OP_W-1:0]  operand_s1, res_s1;
	logic [DIMS-1:0]  start_s1, end_s1;

	always_comb begin
		idx_chunk = '0;
		crd_chunk = '0;
		for (int r = 0; r < DIMS; r++) begin
			if (C * DIMS + r < OP_W) begin
				idx_chunk[r] = in_operand[OP_IW'(C * DIMS + r)];
			end
			if (r * BITS + C < OP_W) begin
				crd_chunk[DIMS-1-r] = in_operand[OP_IW'(r * BITS + C)];
			end
		end

		t  = travel_pos(in_start ^ in_end);
		ra = (32'(t) == DIMS - 1) ? '0 : TW'(t + 1'b1);

		res_next = in_res;
		if (in_cmd == CMD_TO_COORD) begin
			sub_i = idx_chunk;
			cc    = rot_l(gray(idx_chunk), ra) ^ in_start;
			for (int r = 0; r < DIMS; r++) begin
				if (r * BITS + C < OP_W) begin
					res_next[OP_IW'(r * BITS + C)] = cc[DIMS-1-r];
				end
			end
		end else begin
			cc    = crd_chunk;
			sub_i = gray_inv(rot_r(crd_chunk ^ in_start, ra));
			for (int r = 0; r < DIMS; r++) begin
				if (C * DIMS + r < OP_W) begin
					res_next[OP_IW'(C * DIMS + r)] = sub_i[r];
				end
			end
		end

		// Child cube corners: entry of the sub-cube and exit clamped to the top.
		si      = (sub_i == '0) ? '0 : ((sub_i - 1'b1) & ~DIMS'(1));
		ei_wide = ({1'b0, sub_i} + 1'b1) | (DIMS+1)'(1);
		ei      = ei_wide[DIMS] ? '1 : ei_wide[DIMS-1:0];

		start_next = rot_l(gray(si), ra) ^ in_start;
		end_next   = rot_l(gray(ei), ra) ^ in_start;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1     <= in_cmd;
			operand_s1 <= in_operand;
			res_s1     <= res_next;
			start_s1   <= start_next;
			end_s1     <= end_next;
		end
	end

	assign out_valid   = valid_s1;
	assign out_cmd     = cmd_s1;
	assign out_operand = operand_s1;
	assign out_res     = res_s1;
	assign out_start   = start_s1;
	assign out_end     = end_s1;

endmodule
`default_nettype wire

// File: rtl/core/hilbert_curve_index_convert_core.sv
// Top level of the Hilbert curve index converter: a chain of one stage per level.
`default_nettype none
// Converts a DIMS*BITS-bit Hilbert curve index into DIMS packed coordinates of
// BITS bits (cmd CMD_TO_COORD) or back (cmd CMD_TO_INDEX); coordinate k sits in
// operand bits k*BITS upward, and bit positions at or above 64 read as zero and
// are dropped. The converter is a pipeline of BITS stages, one per curve level
// from the most significant chunk down; each stage computes its chunk through a
// rotated Gray code and hands the child cube's start and end corners to the next.
// The result of a transaction passes through the stage registers in level order
// and is presented from the last; one transaction can be accepted every cycle
// while the response channel does not stall. Every stage has its own valid bit
// and a ready that opens when the stage is empty or drains, so bubbles close up
// and a stalled response holds the pipeline without loss; the last stage
// register drives the response channel directly. No configuration and no state
// carry from one transaction to the next.
module hilbert_curve_index_convert_core #(
	parameter int DIMS = hcic_pkg::DIMS_DEF,
	parameter int BITS = hcic_pkg::BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hcic_in_if.sink     req,
	hcic_out_if.source  rsp
);
	import hcic_pkg::*;

	// End corner of the root cube.
	localparam int              END_POS = (BITS + 1) % DIMS;
	localparam logic [DIMS-1:0] END0    = {{(DIMS-1){1'b0}}, 1'b1} << END_POS;

	logic              v     [BITS+1];
	logic              rdy   [BITS+1];
	hcic_cmd_t         cmd   [BITS+1];
	logic [OP_W-1:0]   opnd  [BITS+1];
	logic [OP_W-1:0]   res   [BITS+1];
	logic [DIMS-1:0]   st    [BITS+1];
	logic [DIMS-1:0]   en    [BITS+1];

	// Feed the first level from the request channel with the root corners.
	assign v[0]      = req.valid;
	assign req.ready = rdy[0];
	assign cmd[0]    = req.cmd;
	assign opnd[0]   = req.operand_in;
	assign res[0]    = '0;
	assign st[0]     = '0;
	assign en[0]     = END0;

	for (genvar j = 0; j < BITS; j++) begin : g_level
		hcic_level #(
			.DIMS  (DIMS),
			.BITS  (BITS),
			.LEVEL (j)
		) u_level (
			.clk         (clk),
			.arst_n      (arst_n),
			.in_valid    (v[j]),
			.in_ready    (rdy[j]),
			.in_cmd      (cmd[j]),
			.in_operand  (opnd[j]),
			.in_res      (res[j]),
			.in_start    (st[j]),
			.in_end      (en[j]),
			.out_valid   (v[j+1]),
			.out_ready   (rdy[j+1]),
			.out_cmd     (cmd[j+1]),
			.out_operand (opnd[j+1]),
			.out_res     (res[j+1]),
			.out_start   (st[j+1]),
			.out_end     (en[j+1])
		);
	end

	// Drive the response from the last level's register.
	assign rsp.valid       = v[BITS];
	assign rsp.operand_out = res[BITS];
	assign rdy[BITS]       = rsp.ready;

`ifndef SYNTHESIS
	// A draining response leaves every stage free to advance.
	a_flow_through: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.ready |-> req.ready)
		else $error("request stalled while response is drained");

	// An empty first stage always takes a transaction.
	a_first_open: assert property (@(posedge clk) disable iff (!arst_n)
		!v[1] |-> req.ready)
		else $error("first stage empty but request not ready");

	// A new result comes only from an item that stood in the stage before.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(v[BITS-1] && rdy[BITS-1]))
		else $error("result appeared without a source item");

	// A result that is not taken stays in place.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.operand_out)))
		else $error("stalled result changed or dropped");
`endif

endmodule
`default_nettype wire
